### rtl/tsq_pkg.sv
// Shared types and constants for the tagged slot queue.
// No dependencies; used by the interfaces, the slot cell and the top level.
`timescale 1ns / 1ps

package tsq_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned WORD_W = 64;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    STS_QUEUED    = 3'd0,
    STS_DELIVERED = 3'd1,
    STS_NONE      = 3'd2,
    STS_REFUSED   = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  // payload words of one slot
  typedef struct packed {
    word_t handler;
    word_t ctx;
    word_t arg1;
    word_t arg2;
  } payload_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic     capture;     // request accepted this cycle: latch match/free flags
    logic     fire;        // evaluation commits this cycle
    logic     do_queue;    // commit writes the first free slot
    logic     do_drain;    // commit clears the first matching slot
    word_t    self_thread; // valid with capture
    word_t    tag;         // valid with fire
    payload_t data;        // valid with fire
  } tsq_ctl_t;

endpackage

### rtl/tsq_if.sv
// Handshake channels of the tagged slot queue: request and response.
// Depends on tsq_pkg.
`timescale 1ns / 1ps

interface tsq_req_if;
  import tsq_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  word_t thread_id;
  word_t self_thread;
  logic  target_ok;
  word_t handler;
  word_t context_req;
  word_t sys_arg1;
  word_t sys_arg2;

  modport source (output valid, action, thread_id, self_thread, target_ok, handler,
                  context_req, sys_arg1, sys_arg2, input ready);
  modport sink   (input valid, action, thread_id, self_thread, target_ok, handler,
                  context_req, sys_arg1, sys_arg2, output ready);
endinterface

interface tsq_rsp_if;
  import tsq_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] status;
  word_t      out_handler;
  word_t      out_context;
  word_t      out_arg1;
  word_t      out_arg2;

  modport source (output valid, status, out_handler, out_context, out_arg1, out_arg2,
                  input ready);
  modport sink   (input valid, status, out_handler, out_context, out_arg1, out_arg2,
                  output ready);
endinterface

### rtl/tagged_slot_queue.sv
// Top level of the tagged slot queue: controller, chain of slot cells and
// response register. Depends on tsq_pkg, tsq_req_if/tsq_rsp_if and tsq_cell.
`timescale 1ns / 1ps

// Channel | Dir | Beat contents
// req_i   | in  | action, thread_id, self_thread, target_ok, handler, context_req, args
// rsp_o   | out | status, out_handler, out_context, out_arg1, out_arg2
//
// Each request is accepted in ST_IDLE, which latches the per-cell tag compare;
// ST_EVAL then ripples the first-hit chain through the cells and commits.
// A new request is taken only in idle, so none is accepted before the last one commits.
// Reset clears every used flag at once; no clearing pass.
// A stalled response holds the commit until the response register frees up.

module tagged_slot_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  tsq_req_if.sink  req_i,
  tsq_rsp_if.source rsp_o
);
  import tsq_pkg::*;

  state_e   state_q, state_d;
  logic     accept, fire, out_free;

  // command latched at accept
  logic     cmd_drain_q, cmd_refuse_q;
  word_t    cmd_tag_q;
  payload_t cmd_data_q;

  logic     refuse_in;
  logic     tag_self;

  tsq_ctl_t ctl;
  logic     [SLOTS:0] taken;
  payload_t bus [SLOTS+1];
  logic     [SLOTS-1:0] win, used;

  // response register
  logic     out_valid_q, out_valid_d;
  status_e  out_status_q, status_d;
  payload_t out_data_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign out_free    = ~out_valid_q | rsp_o.ready;

  // thread tags 0, all-ones and all-ones-minus-one address the caller itself
  assign tag_self  = (req_i.thread_id == '0) || (req_i.thread_id == '1) ||
                     (req_i.thread_id == {{(WORD_W-1){1'b1}}, 1'b0});
  assign refuse_in = ~req_i.action & (~req_i.target_ok | (req_i.handler == '0));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_drain_q     <= req_i.action;
      cmd_refuse_q    <= refuse_in;
      cmd_tag_q       <= tag_self ? req_i.self_thread : req_i.thread_id;
      cmd_data_q      <= '{handler: req_i.handler, ctx: req_i.context_req,
                           arg1: req_i.sys_arg1, arg2: req_i.sys_arg2};
    end
  end

  // controller
  always_comb begin
    state_d = state_q;
    fire    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          fire    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // broadcast to the cells
  assign ctl.capture     = accept;
  assign ctl.fire        = fire;
  assign ctl.do_queue    = ~cmd_drain_q & ~cmd_refuse_q;
  assign ctl.do_drain    = cmd_drain_q;
  assign ctl.self_thread = req_i.self_thread;
  assign ctl.tag         = cmd_tag_q;
  assign ctl.data        = cmd_data_q;

  // slot chain: cell 0 has top priority, taken ripples toward the last cell
  assign taken[0] = 1'b0;
  assign bus[0]   = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tsq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .taken_i (taken[g]),
      .taken_o (taken[g+1]),
      .bus_i   (bus[g]),
      .bus_o   (bus[g+1]),
      .win_o   (win[g]),
      .used_o  (used[g])
    );
  end

  // status of the evaluated request
  always_comb begin
    priority if (cmd_refuse_q) begin
      status_d = STS_REFUSED;
    end else if (cmd_drain_q) begin
      status_d = taken[SLOTS] ? STS_DELIVERED : STS_NONE;
    end else begin
      status_d = taken[SLOTS] ? STS_QUEUED : STS_FULL;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // bus end is zero unless a drain found its slot
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= status_d;
      out_data_q   <= bus[SLOTS];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_handler = out_data_q.handler;
  assign rsp_o.out_context = out_data_q.ctx;
  assign rsp_o.out_arg1    = out_data_q.arg1;
  assign rsp_o.out_arg2    = out_data_q.arg2;

  // at most one slot wins the chain
  a_one_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(win))
    else $error("more than one slot selected");

  // an accepted request always moves to evaluation
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EVAL))
    else $error("accepted request not evaluated");

  // a commit always leaves a response pending
  a_fire_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("commit without response");

  // a refused request leaves the table untouched
  a_refuse_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_refuse_q) |=> $stable(used))
    else $error("refused request changed the table");

endmodule

### rtl/tsq_cell.sv
// One slot of the queue: used flag, thread tag, payload, and its link in the
// first-hit priority chain. Depends on tsq_pkg.
`timescale 1ns / 1ps

module tsq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsq_pkg::tsq_ctl_t ctl_i,
  input  logic              taken_i,
  output logic              taken_o,
  input  tsq_pkg::payload_t bus_i,
  output tsq_pkg::payload_t bus_o,
  output logic              win_o,
  output logic              used_o
);
  import tsq_pkg::*;

  logic     used_q, used_d;
  word_t    thread_q;
  payload_t data_q;
  logic     match_q, free_q;
  logic     cand;

  // flags latched at accept; slot contents only change on fire
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      match_q <= used_q & (thread_q == ctl_i.self_thread);
      free_q  <= ~used_q;
    end
  end

  assign cand    = ctl_i.do_queue ? free_q : (ctl_i.do_drain & match_q);
  assign win_o   = cand & ~taken_i;
  assign taken_o = taken_i | cand;
  assign bus_o   = (win_o && ctl_i.do_drain) ? (bus_i | data_q) : bus_i;
  assign used_o  = used_q;

  always_comb begin
    used_d = used_q;
    if (ctl_i.fire && win_o) begin
      used_d = ctl_i.do_queue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire && win_o && ctl_i.do_queue) begin
      thread_q <= ctl_i.tag;
      data_q   <= ctl_i.data;
    end
  end

endmodule
